// ===== hw/rtl/wafv_pkg.sv =====
`default_nettype none

package wafv_pkg;

  // Field and datapath widths
  localparam int VEL_W     = 20;
  localparam int DV_W      = VEL_W + 1;
  localparam int DT_W      = 20;
  localparam int ACC_W     = 24;
  localparam int THR_W     = 10;
  localparam int PROD_W    = 2 * DV_W;
  localparam int SQ_W      = PROD_W + 2;
  localparam int QUO_W     = ACC_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [THR_W-1:0] THR_RESET = 10'd10;
  localparam logic [DV_W-1:0]  US_PER_S  = 21'd1000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_THR = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX  = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN  = 24'sh800000;
  localparam logic [QUO_W-1:0]        Q_HALF   = 24'h800000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_VEL,
    OP_SQ_DV,
    OP_SCALE,
    OP_RAW,
    OP_TAKE_RAW,
    OP_WINIT,
    OP_WALK,
    OP_AVG,
    OP_PUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQV,
    ST_SQD,
    ST_SCL,
    ST_RAW,
    ST_DIVR,
    ST_WINIT,
    ST_WALK,
    ST_AVG,
    ST_DIVA,
    ST_PUSH
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } cmd_t;

  typedef struct packed {
    logic rep;
    logic div_busy;
    logic walk_last;
    logic out_free;
  } sts_t;

  function automatic logic [DV_W-1:0] mag_dv(input logic signed [DV_W-1:0] a);
    return a[DV_W-1] ? DV_W'(-a) : DV_W'(a);
  endfunction

  // Apply sign and clamp an unsigned quotient to the 24-bit output range
  function automatic logic signed [ACC_W-1:0] sat_quot(input logic ovf, input logic neg,
                                                       input logic [QUO_W-1:0] q);
    logic signed [ACC_W-1:0] r;
    if (ovf) begin
      r = neg ? ACC_MIN : ACC_MAX;
    end else if (neg) begin
      r = (q > Q_HALF) ? ACC_MIN : -$signed(q);
    end else begin
      r = q[QUO_W-1] ? ACC_MAX : $signed(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wafv_in_if.sv =====
`default_nettype none

interface wafv_in_if import wafv_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic [DT_W-1:0]         dt_us;

  modport source (output valid, output vel_x, output vel_y, output vel_z, output dt_us,
                  input ready);
  modport sink (input valid, input vel_x, input vel_y, input vel_z, input dt_us,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wafv_out_if.sv =====
`default_nettype none

interface wafv_out_if import wafv_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;

  modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
  modport sink (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/weighted_accel_from_velocity_core.sv =====
// Each beat runs through the squares, the scale, a divide by dt, the walk over the n
// stored entries (0..HISTORY_DEPTH) and a divide by the weight total; a repeated sample
// skips the first divide. The next beat waits until the last is pushed; the two 24-step
// serial divides per axis, the walk (one entry per cycle) and output waits set the pace.
// Reset (rst_n low, synchronous): thresholds go to 10, previous velocity to zero and the
// history to empty; the history RAM itself is not cleared.
`default_nettype none

module weighted_accel_from_velocity_core import wafv_pkg::*; #(
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wafv_in_if.sink                    in_ch,
  wafv_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [THR_W-1:0]      cfg_data
);

  // Controller and datapath talk only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept a beat in idle, then step through
  //   squares of v and dv -> repeat check and dv*1e6 -> divide by dt (skipped on a repeat)
  //   -> history walk with linear weights -> divide by the weight total -> push.
  wafv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: one multiplier and one serial divider per axis, the history
  // ring in a RAM, and an output register so the next beat can be taken
  // while a finished result still waits on the output side.
  wafv_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_vel_x  (in_ch.vel_x),
    .in_vel_y  (in_ch.vel_y),
    .in_vel_z  (in_ch.vel_z),
    .in_dt_us  (in_ch.dt_us),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_acc_x (out_ch.acc_x),
    .out_acc_y (out_ch.acc_y),
    .out_acc_z (out_ch.acc_z)
  );

  // A new beat only enters with the dividers at rest.
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !sts.div_busy)
    else $error("input beat accepted while divider busy");

  // Never overwrite a result that has not been taken.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH) |-> sts.out_free)
    else $error("push into occupied output register");

  // A push shows up on the output the next cycle.
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH) |=> out_ch.valid)
    else $error("push did not raise output valid");

  // Divider starts only when idle.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/wafv_ram.sv =====
`default_nettype none

module wafv_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 10
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wafv_div.sv =====
`default_nettype none

module wafv_div import wafv_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [PROD_W-1:0]       mag,
  input  wire logic                    neg,
  input  wire logic [DT_W-1:0]         den,
  output logic                         busy,
  output logic signed [ACC_W-1:0]      res
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DT_W-1:0]  rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DT_W-1:0]  den_r;
  logic             neg_r;
  logic             ovf_r;

  logic [DT_W:0]    sh;
  logic [DT_W:0]    diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign sh   = {rem_r, quo_r[QUO_W-1]};
  assign ge   = (sh >= {1'b0, den_r});
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      neg_r <= neg;
      // Quotient will not fit in QUO_W bits: saturate
      ovf_r <= ((DT_W + QUO_W)'(mag) >= {den, {QUO_W{1'b0}}});
      rem_r <= DT_W'(mag >> QUO_W);
      quo_r <= mag[QUO_W-1:0];
      cnt_r <= CNT_W'(QUO_W);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DT_W-1:0] : sh[DT_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign res  = sat_quot(ovf_r, neg_r, quo_r);

endmodule

`default_nettype wire

// ===== hw/rtl/wafv_ctrl.sv =====
`default_nettype none

module wafv_ctrl import wafv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SQV;
        end
      end
      ST_SQV: begin
        cmd.op    = OP_SQ_VEL;
        state_nxt = ST_SQD;
      end
      ST_SQD: begin
        cmd.op    = OP_SQ_DV;
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        // Repeated sample: skip the divide
        cmd.op        = OP_RAW;
        cmd.div_start = !sts.rep;
        state_nxt     = sts.rep ? ST_WINIT : ST_DIVR;
      end
      ST_DIVR: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_TAKE_RAW;
          state_nxt = ST_WINIT;
        end
      end
      ST_WINIT: begin
        cmd.op    = OP_WINIT;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.op = OP_WALK;
        if (sts.walk_last) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.op        = OP_AVG;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVA;
      end
      ST_DIVA: begin
        if (!sts.div_busy) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // Hold until the output register is free
        if (sts.out_free) begin
          cmd.op    = OP_PUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wafv_dpath.sv =====
`default_nettype none

module wafv_dpath import wafv_pkg::*; #(
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic signed [VEL_W-1:0] in_vel_x,
  input  wire logic signed [VEL_W-1:0] in_vel_y,
  input  wire logic signed [VEL_W-1:0] in_vel_z,
  input  wire logic [DT_W-1:0]         in_dt_us,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [THR_W-1:0]        cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [ACC_W-1:0]      out_acc_x,
  output logic signed [ACC_W-1:0]      out_acc_y,
  output logic signed [ACC_W-1:0]      out_acc_z
);

  localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW      = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_MAX = (HISTORY_DEPTH + 1) * (HISTORY_DEPTH + 2) / 2;
  localparam int TW      = $clog2(TOT_MAX + 1);
  localparam int ACCU_W  = ACC_W + TW;
  localparam logic [CW:0]   DEPTH_C = (CW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_N = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  // Ring slot of the entry that is age places younger than the oldest
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] age);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(age);
    if (s >= DEPTH_C) begin
      s = s - DEPTH_C;
    end
    return s[AW-1:0];
  endfunction

  logic [THR_W-1:0]         mthr_r;
  logic [THR_W-1:0]         rthr_r;
  logic signed [VEL_W-1:0]  prev_r [3];
  logic signed [VEL_W-1:0]  v_r [3];
  logic signed [DV_W-1:0]   dv_r [3];
  logic [DT_W-1:0]          dt_r;
  logic [PROD_W-1:0]        prod_r [3];
  logic [SQ_W-1:0]          speed_r;
  logic                     rep_r;
  logic signed [ACC_W-1:0]  raw_r [3];
  logic signed [ACCU_W-1:0] acc_r [3];
  logic [CW-1:0]            idx_r;
  logic [CW-1:0]            count_r;
  logic [AW-1:0]            oldest_r;
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  out_acc_r [3];

  logic signed [VEL_W-1:0]  in_vel [3];
  logic [DV_W-1:0]          mul_a [3];
  logic [DV_W-1:0]          mul_b [3];
  logic [PROD_W-1:0]        mul_p [3];
  logic [SQ_W-1:0]          sq_sum;
  logic [2*THR_W-1:0]       mthr_sq;
  logic [2*THR_W-1:0]       rthr_sq;
  logic [CW-1:0]            age_sel;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [3*ACC_W-1:0]       rdata;
  logic signed [ACC_W-1:0]  rd [3];
  logic [CW:0]              cnt1;
  logic [CW:0]              cnt2;
  logic [2*CW+1:0]          tot_full;
  logic signed [ACC_W+CW+1:0] ip [3];
  logic signed [ACC_W+CW:0]   wprod [3];
  logic [ACCU_W-1:0]        acc_abs [3];
  logic [PROD_W-1:0]        div_mag [3];
  logic                     div_neg [3];
  logic [DT_W-1:0]          div_den;
  logic [2:0]               div_busy;
  logic signed [ACC_W-1:0]  div_res [3];

  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;

  // One multiplier per lane: |v|^2, |dv|^2, then |dv| * 1e6
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_a[k] = mag_dv(dv_r[k]);
      mul_b[k] = mag_dv(dv_r[k]);
      case (cmd.op)
        OP_SQ_VEL: begin
          mul_a[k] = mag_dv(DV_W'(v_r[k]));
          mul_b[k] = mul_a[k];
        end
        OP_SCALE: begin
          mul_b[k] = US_PER_S;
        end
        default: ;
      endcase
      mul_p[k] = mul_a[k] * mul_b[k];
    end
  end

  assign sq_sum  = SQ_W'(prod_r[0]) + SQ_W'(prod_r[1]) + SQ_W'(prod_r[2]);
  assign mthr_sq = mthr_r * mthr_r;
  assign rthr_sq = rthr_r * rthr_r;

  // History addressing: newest entry during scale, walk index otherwise
  assign age_sel = (cmd.op == OP_SCALE) ? (count_r - 1'b1) : idx_r;
  assign raddr   = slot_of(oldest_r, age_sel);
  assign waddr   = (count_r < DEPTH_N) ? slot_of(oldest_r, count_r) : oldest_r;

  wafv_ram #(
    .WIDTH (3 * ACC_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.op == OP_PUSH),
    .waddr (waddr),
    .wdata ({div_res[2], div_res[1], div_res[0]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt1     = (CW + 1)'(count_r) + (CW + 1)'(1);
  assign cnt2     = cnt1 + (CW + 1)'(1);
  assign tot_full = cnt1 * cnt2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd[k]      = $signed(rdata[k*ACC_W +: ACC_W]);
      ip[k]      = raw_r[k] * $signed({1'b0, cnt1});
      wprod[k]   = rd[k] * $signed({1'b0, idx_r});
      acc_abs[k] = acc_r[k][ACCU_W-1] ? ACCU_W'(-acc_r[k]) : ACCU_W'(acc_r[k]);
      if (cmd.op == OP_AVG) begin
        div_mag[k] = PROD_W'(acc_abs[k]);
        div_neg[k] = acc_r[k][ACCU_W-1];
      end else begin
        div_mag[k] = prod_r[k];
        div_neg[k] = dv_r[k][DV_W-1];
      end
    end
  end

  assign div_den = (cmd.op == OP_AVG) ? DT_W'(tot_full >> 1) : dt_r;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    wafv_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.div_start),
      .mag   (div_mag[k]),
      .neg   (div_neg[k]),
      .den   (div_den),
      .busy  (div_busy[k]),
      .res   (div_res[k])
    );
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mthr_r      <= THR_RESET;
      rthr_r      <= THR_RESET;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MOVING_THR: mthr_r <= cfg_data;
          CFG_REPEAT_THR: rthr_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          prev_r[k] <= in_vel[k];
        end
      end
      if (cmd.op == OP_PUSH) begin
        out_valid_r <= 1'b1;
        if (count_r < DEPTH_N) begin
          count_r <= count_r + 1'b1;
        end else begin
          oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          v_r[k]  <= in_vel[k];
          dv_r[k] <= DV_W'(in_vel[k]) - DV_W'(prev_r[k]);
        end
        dt_r <= (in_dt_us == '0) ? DT_W'(1) : in_dt_us;
      end
      OP_SQ_VEL: begin
        prod_r <= mul_p;
      end
      OP_SQ_DV: begin
        speed_r <= sq_sum;
        prod_r  <= mul_p;
      end
      OP_SCALE: begin
        rep_r  <= (speed_r > SQ_W'(mthr_sq)) && (sq_sum <= SQ_W'(rthr_sq));
        prod_r <= mul_p;
      end
      OP_RAW: begin
        if (rep_r) begin
          for (int k = 0; k < 3; k++) begin
            raw_r[k] <= (count_r != '0) ? rd[k] : '0;
          end
        end
      end
      OP_TAKE_RAW: begin
        raw_r <= div_res;
      end
      OP_WINIT: begin
        for (int k = 0; k < 3; k++) begin
          acc_r[k] <= ACCU_W'(ip[k]);
        end
        idx_r <= '0;
      end
      OP_WALK: begin
        // Read data trails the address by the registered RAM read: weight is idx_r
        if (idx_r != '0) begin
          for (int k = 0; k < 3; k++) begin
            acc_r[k] <= acc_r[k] + ACCU_W'(wprod[k]);
          end
        end
        idx_r <= idx_r + 1'b1;
      end
      OP_PUSH: begin
        out_acc_r <= div_res;
      end
      default: ;
    endcase
  end

  assign sts.rep       = rep_r;
  assign sts.div_busy  = |div_busy;
  assign sts.walk_last = (idx_r == count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_acc_x = out_acc_r[0];
  assign out_acc_y = out_acc_r[1];
  assign out_acc_z = out_acc_r[2];

endmodule

`default_nettype wire

// ===== sim/weighted_accel_from_velocity_core_tb.sv =====
`default_nettype none

module weighted_accel_from_velocity_core_tb import wafv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 7;
  localparam int HISTORY_DEPTH   = 10;
  // Allow for the slowest beat plus long random stalls on top
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int MAX_REPORTS     = 10;
  localparam longint MICROS_PER_SEC = 1000000;

  // One expected or observed acceleration triple, index 0 = x, 1 = y, 2 = z
  typedef logic [2:0][ACC_W-1:0] acc_trio_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
    logic [DT_W-1:0]         dt;
  } sample_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,        // velocity beat, checked against the predictor
    ROW_SAMPLE_KNOWN,  // velocity beat with the result typed into the row
    ROW_REG_WRITE      // threshold write, issued once the block has gone idle
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    int                      reg_val;
    int                      vx;
    int                      vy;
    int                      vz;
    int                      dt;
    int                      ex;
    int                      ey;
    int                      ez;
  } stim_row_t;

  // Directed stimulus. Only the first velocity beat carries a typed result: the vehicle
  // counts as moving at threshold zero while a wide repeat window calls the sample
  // repeated, and with nothing stored yet the smoothed output must be zero.
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{ROW_REG_WRITE,    CFG_MOVING_THR,    0,       0,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE,    CFG_REPEAT_THR, 1023,       0,       0,       0,       0, 0, 0, 0},
    '{ROW_SAMPLE_KNOWN, CFG_MOVING_THR,    0,       5,      -3,       1,     100, 0, 0, 0},
    // full-scale step at 1 us saturates the raw x and y values
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,  524287, -524288,       0,       1, 0, 0, 0},
    // same velocity again: repeated sample with history present
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,  524287, -524288,       0,       7, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0, -524288,  524287, -524288, 1048575, 0, 0, 0},
    '{ROW_REG_WRITE,    CFG_MOVING_THR, 1023,       0,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE,    CFG_REPEAT_THR,    0,       0,       0,       0,       0, 0, 0, 0},
    // zero elapsed time counts as one microsecond
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,    1000,       0,       0,       0, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,    1000,       0,       0,       1, 0, 0, 0},
    // speed right at the moving threshold, then just above it
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,    1023,       0,       0,      50, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,    1024,       0,       0,      50, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,    1024,       0,       0,      50, 0, 0, 0},
    '{ROW_REG_WRITE,    CFG_MOVING_THR,   10,       0,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE,    CFG_REPEAT_THR,   10,       0,       0,       0,       0, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,       0,       0,       0,    1000, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,      11,       0,       0,    1000, 0, 0, 0},
    // velocity change right at the repeat threshold
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,      21,       0,       0,    1000, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,      10,       0,       0,    1000, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,       0,       0, -524288,       1, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,       0,       0,  524287,       1, 0, 0, 0},
    // small negative quotients truncate toward zero
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,      -1,      -1,      -1,       3, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0,     123,    -456,     789,      13, 0, 0, 0},
    '{ROW_SAMPLE,       CFG_MOVING_THR,    0, -524288, -524288, -524288, 1048575, 0, 0, 0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [THR_W-1:0]       cfg_data;

  wafv_in_if  in_bus ();
  wafv_out_if out_bus ();

  weighted_accel_from_velocity_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle percentages of the current phase, per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  acc_trio_t expected_accel [$];

  // Predictor state: a private copy of the thresholds, the last velocity and the
  // ring of smoothed outputs, all kept as wide signed integers
  longint thr_moving = 10;
  longint thr_repeat = 10;
  longint prev_vel [3] = '{0, 0, 0};
  longint acc_hist [HISTORY_DEPTH][3];
  int     hist_count  = 0;
  int     hist_oldest = 0;

  string axis_name [3] = '{"acc_x", "acc_y", "acc_z"};

  function automatic longint clamp_acc(input longint v);
    if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
    if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
    return v;
  endfunction

  // Advance the predictor by one accepted beat and return the smoothed acceleration
  function automatic acc_trio_t predict_accel(input sample_t s);
    longint    v [3];
    longint    dv [3];
    longint    raw [3];
    longint    sum [3];
    longint    speed_sq;
    longint    delta_sq;
    longint    dt;
    longint    total;
    longint    w;
    logic      is_repeat;
    int        slot;
    acc_trio_t r;
    v[0] = longint'($signed(s.vx));
    v[1] = longint'($signed(s.vy));
    v[2] = longint'($signed(s.vz));
    dt = (s.dt == '0) ? 1 : longint'(s.dt);
    speed_sq = 0;
    delta_sq = 0;
    for (int k = 0; k < 3; k++) begin
      dv[k] = v[k] - prev_vel[k];
      prev_vel[k] = v[k];
      speed_sq += v[k] * v[k];
      delta_sq += dv[k] * dv[k];
      sum[k] = 0;
    end
    // Moving but barely changed: treat as a duplicate and reuse the newest output
    is_repeat = (speed_sq > thr_moving * thr_moving) && (delta_sq <= thr_repeat * thr_repeat);
    for (int k = 0; k < 3; k++) begin
      if (is_repeat) begin
        raw[k] = (hist_count != 0) ?
                 acc_hist[(hist_oldest + hist_count - 1) % HISTORY_DEPTH][k] : 0;
      end else begin
        raw[k] = clamp_acc((dv[k] * MICROS_PER_SEC) / dt);
      end
    end
    // Linear weights: oldest stored entry 1, current raw value hist_count + 1
    total = 0;
    for (int i = 0; i < hist_count; i++) begin
      w = i + 1;
      total += w;
      for (int k = 0; k < 3; k++) begin
        sum[k] += acc_hist[(hist_oldest + i) % HISTORY_DEPTH][k] * w;
      end
    end
    w = hist_count + 1;
    total += w;
    if (hist_count < HISTORY_DEPTH) begin
      slot = (hist_oldest + hist_count) % HISTORY_DEPTH;
      hist_count++;
    end else begin
      slot = hist_oldest;
      hist_oldest = (hist_oldest + 1) % HISTORY_DEPTH;
    end
    for (int k = 0; k < 3; k++) begin
      sum[k] = clamp_acc((sum[k] + raw[k] * w) / total);
      acc_hist[slot][k] = sum[k];
      r[k] = sum[k][ACC_W-1:0];
    end
    return r;
  endfunction

  // Random beat: mostly smooth trajectories and exact duplicates around the current
  // thresholds, the rest full-range noise and short-interval jumps that saturate
  function automatic sample_t next_random_sample();
    sample_t s;
    int      pick;
    int      span;
    int      v [3];
    pick = $urandom_range(0, 99);
    span = int'(thr_repeat) + 4;
    for (int k = 0; k < 3; k++) begin
      if (pick < 8) begin
        v[k] = int'($urandom_range(0, 60000)) - 30000;
      end else if (pick < 45) begin
        v[k] = int'(prev_vel[k]) + int'($urandom_range(0, 2 * span)) - span;
      end else if (pick < 60) begin
        v[k] = int'(prev_vel[k]);
      end else if (pick < 80) begin
        v[k] = int'($signed(VEL_W'($urandom())));
      end else begin
        v[k] = int'($urandom_range(0, 8191)) - 4096;
      end
      if (v[k] > 524287) v[k] = 524287;
      if (v[k] < -524288) v[k] = -524288;
    end
    s.vx = VEL_W'(v[0]);
    s.vy = VEL_W'(v[1]);
    s.vz = VEL_W'(v[2]);
    if (pick < 45) begin
      s.dt = DT_W'($urandom_range(8000, 12000));
    end else if (pick < 60) begin
      s.dt = DT_W'($urandom_range(1, 20000));
    end else if (pick < 80) begin
      s.dt = DT_W'($urandom());
    end else begin
      s.dt = DT_W'($urandom_range(0, 300));
    end
    return s;
  endfunction

  // Present one beat from the falling edge, hold it until accepted, then predict
  task automatic send_sample(input sample_t s, input logic known, input acc_trio_t known_acc);
    acc_trio_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      // drop valid and scramble the payload while idle
      in_bus.valid = 1'b0;
      in_bus.vel_x = VEL_W'($urandom());
      in_bus.vel_y = VEL_W'($urandom());
      in_bus.vel_z = VEL_W'($urandom());
      in_bus.dt_us = DT_W'($urandom());
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.vel_x = s.vx;
    in_bus.vel_y = s.vy;
    in_bus.vel_z = s.vz;
    in_bus.dt_us = s.dt;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = predict_accel(s);
    expected_accel.insert(expected_accel.size(), known ? known_acc : predicted);
  endtask

  // Lower valid and hold until every expected result has been taken
  task automatic wait_for_results();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_accel.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[THR_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MOVING_THR) begin
      thr_moving = longint'(value[THR_W-1:0]);
    end else begin
      thr_repeat = longint'(value[THR_W-1:0]);
    end
  endtask

  // Result side: stall at random, changing ready only on the falling edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare every accepted result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    acc_trio_t got;
    acc_trio_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got[0] = out_bus.acc_x;
      got[1] = out_bus.acc_y;
      got[2] = out_bus.acc_z;
      if (expected_accel.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result beat with no sample pending: %0d %0d %0d", $time,
                   $signed(got[0]), $signed(got[1]), $signed(got[2]));
        end
      end else begin
        want = expected_accel[0];
        expected_accel.delete(0);
        for (int k = 0; k < 3; k++) begin
          if (got[k] !== want[k]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: %s mismatch, expected %0d, got %0d", $time, axis_name[k],
                       $signed(want[k]), $signed(got[k]));
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    sample_t   s;
    acc_trio_t known;
    int        mov_thr;
    int        rep_thr;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MOVING_THR;
    cfg_data     = '0;
    in_bus.valid = 1'b0;
    in_bus.vel_x = '0;
    in_bus.vel_y = '0;
    in_bus.vel_z = '0;
    in_bus.dt_us = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: walk the table, no idling
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG_WRITE) begin
        wait_for_results();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        s.vx = row.vx[VEL_W-1:0];
        s.vy = row.vy[VEL_W-1:0];
        s.vz = row.vz[VEL_W-1:0];
        s.dt = row.dt[DT_W-1:0];
        known[0] = row.ex[ACC_W-1:0];
        known[1] = row.ey[ACC_W-1:0];
        known[2] = row.ez[ACC_W-1:0];
        send_sample(s, row.kind == ROW_SAMPLE_KNOWN, known);
      end
    end

    // Random part: each phase gets its own thresholds and idling pattern
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: begin mov_thr = 10;   rep_thr = 10;   end
        1: begin mov_thr = 0;    rep_thr = 0;    end
        2: begin mov_thr = 1023; rep_thr = 1023; end
        3: begin mov_thr = 0;    rep_thr = 1023; end
        4: begin mov_thr = 1023; rep_thr = 0;    end
        default: begin
          mov_thr = $urandom_range(0, 1023);
          rep_thr = $urandom_range(0, 1023);
        end
      endcase
      write_reg(CFG_MOVING_THR, mov_thr);
      write_reg(CFG_REPEAT_THR, rep_thr);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (ITEMS_PER_PHASE) send_sample(next_random_sample(), 1'b0, '0);
    end

    // Let the last results out, then give the block time to show any stray beat
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_accel.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
